[src/iira_pkg.sv]
// Package: request/response types, mode and status codes for the indexed insert/remove array.
package iira_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 8;
  localparam int OCNT_W       = 9;
  localparam int GRP_N        = 16;
  localparam int GRP_W        = 4;
  localparam int RD_N         = GRP_N * GRP_N;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_WRITE  = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]              mode;
    logic [IDX_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [OCNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    logic app_en;
    logic wr_en;
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

[src/indexed_insert_remove_array.sv]
// Top level: ordered array of signed entries with append, insert, read, write and remove.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | in_req  (mode, index, value)
//  out_    | out       | out_valid/out_stall| out_rsp (read_value, status, count)
//
// Each request passes through accept, cell update with first read-mux stage, and
// second read-mux stage into the output register.
// All cells shift in parallel in the update cycle; the 16x16 registered read tree sets depth.
// rst_n (synchronous, active low) clears the count and control; cell data is not reset.
// A held result in the output register does not block acceptance of the next request;
// the finishing step waits only while the output register is full and stalled.
module indexed_insert_remove_array #(
  parameter int CAPACITY = iira_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  iira_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output iira_pkg::rsp_t out_rsp
);
  import iira_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  req_t             req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             rd_bad_r, rd_bad_nxt;
  logic signed [DATA_W-1:0] grp_r [GRP_N];
  logic signed [DATA_W-1:0] grp_nxt [GRP_N];
  rsp_t             out_r;
  logic             out_valid_r;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_vec [RD_N];
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] tgt_pos;
  logic             idx_ok;
  logic             is_full;
  logic             exec;
  logic             fin_go;
  logic             in_acc;
  logic signed [DATA_W-1:0] rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign exec      = (state_r == ST_EXEC);
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign idx_ok  = CMP_W'(req_r.index) < CMP_W'(cnt_r);
  assign is_full = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl        = '0;
    cnt_nxt    = cnt_r;
    status_nxt = STAT_DONE;
    rd_ok_nxt  = 1'b0;
    rd_bad_nxt = 1'b0;
    tgt_pos    = CNT_W'(req_r.index);
    case (req_r.mode)
      MODE_APPEND: begin
        tgt_pos = cnt_r;
        if (is_full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.app_en = exec;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        if (!idx_ok) begin
          status_nxt = STAT_BAD_INDEX;
        end else if (is_full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.ins_en = exec;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (idx_ok) begin
          rd_ok_nxt = 1'b1;
        end else begin
          rd_bad_nxt = 1'b1;
          status_nxt = STAT_BAD_INDEX;
        end
      end
      MODE_WRITE: begin
        if (idx_ok) begin
          ctl.wr_en = exec;
        end else begin
          status_nxt = STAT_BAD_INDEX;
        end
      end
      MODE_REMOVE: begin
        if (idx_ok) begin
          ctl.rem_en = exec;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = STAT_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_q;
    logic signed [DATA_W-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end
    iira_cell #(
      .CNT_W (CNT_W),
      .POS   (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .tgt_pos  (tgt_pos),
      .wr_value (req_r.value),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i])
    );
  end

  for (genvar j = 0; j < RD_N; j++) begin : g_rdvec
    if (j < CAPACITY) begin : g_used
      assign rd_vec[j] = cell_q[j];
    end else begin : g_pad
      assign rd_vec[j] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_nxt[g] = rd_vec[{GRP_W'(g), req_r.index[GRP_W-1:0]}];
    end
  end

  always_comb begin
    rd_data = '0;
    if (rd_ok_r) begin
      rd_data = grp_r[req_r.index[IDX_W-1:GRP_W]];
    end else if (rd_bad_r) begin
      rd_data = -32'sd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        cnt_r <= cnt_nxt;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req;
    end
    if (exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
      rd_bad_r <= rd_bad_nxt;
      for (int g = 0; g < GRP_N; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (fin_go) begin
      out_r.read_value <= rd_data;
      out_r.status     <= status_r;
      out_r.count      <= OCNT_W'(cnt_r);
    end
  end

endmodule

[src/iira_cell.sv]
// One storage cell of the array: holds an entry, loads new data or a neighbor's entry.
module iira_cell #(
  parameter int CNT_W = 9,
  parameter int POS   = 0
) (
  input  logic                             clk,
  input  iira_pkg::cell_ctl_t              ctl,
  input  logic [CNT_W-1:0]                 tgt_pos,
  input  logic signed [iira_pkg::DATA_W-1:0] wr_value,
  input  logic signed [iira_pkg::DATA_W-1:0] left_q,
  input  logic signed [iira_pkg::DATA_W-1:0] right_q,
  output logic signed [iira_pkg::DATA_W-1:0] q
);
  import iira_pkg::*;

  localparam logic [CNT_W-1:0] POS_V = CNT_W'(POS);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     at_tgt;
  logic                     above_tgt;

  assign at_tgt    = (POS_V == tgt_pos);
  assign above_tgt = (POS_V > tgt_pos);

  always_comb begin
    entry_nxt = entry_r;
    if ((ctl.app_en || ctl.wr_en || ctl.ins_en) && at_tgt) begin
      entry_nxt = wr_value;
    end else if (ctl.ins_en && above_tgt) begin
      entry_nxt = left_q;
    end else if (ctl.rem_en && (at_tgt || above_tgt)) begin
      entry_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule
